// ----- rtl/core/sal_pkg.sv -----
// Shared types, sizes and codes for the sorted array linked list block.
// Depends on nothing; every other file of the block imports it.
`default_nettype none
package sal_pkg;

  localparam int ENTRIES = 32;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int LINK_W  = $clog2(ENTRIES + 1);
  localparam int POS_W   = 5;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [LINK_W-1:0] link_t;
  typedef logic signed [31:0] key_t;
  typedef logic [31:0]       word_t;
  typedef logic [POS_W-1:0]  pos_t;

  localparam link_t NULL_LINK = LINK_W'(ENTRIES);

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_FULL      = 2'd1,
    ST_FOUND     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FREE,
    S_WALK,
    S_LINK_NEW,
    S_LINK_PREV
  } state_t;

  // One access cycle of the entry store.
  typedef struct packed {
    logic  rd_en;
    idx_t  rd_addr;
    logic  kp_we;
    idx_t  kp_addr;
    key_t  key;
    word_t payload;
    logic  lk_we;
    idx_t  lk_addr;
    link_t lk_data;
  } store_req_t;

  typedef struct packed {
    key_t  key;
    word_t payload;
    link_t link;
  } store_rsp_t;

  function automatic logic is_live(link_t l);
    return l < NULL_LINK;
  endfunction

  // Any link at or above the pool size counts as null.
  function automatic link_t link_of(link_t l);
    return is_live(l) ? l : NULL_LINK;
  endfunction

  function automatic idx_t to_idx(link_t l);
    return l[IDX_W-1:0];
  endfunction

  function automatic pos_t pos_of(link_t l);
    logic [31:0] w;
    w = 32'(l);
    return w[POS_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/sorted_array_linked_list.sv -----
// Top level of the sorted array linked list: walk sequencer and result register.
// Depends on sal_pkg, sal_store and sal_cmp.
//
// Usage:
//   A command transfer happens at a rising edge with start high and busy low.
//   in_command selects insert (store in_key/in_payload in ascending signed key
//   order) or search (find the first entry whose key equals in_key).
//   Exactly one result follows each command: out_strobe is high for one cycle
//   with out_status, out_position and out_found_payload; the receiver cannot
//   stall, so the result must be taken in that cycle.
// Walk:
//   One list entry is visited per cycle through the single store read port
//   and the shared comparator. A search answers when its walk stops. An
//   insert first reads the free slot's link, then walks, then writes the new
//   slot and, unless it becomes the head, the predecessor's link. A full-pool
//   insert answers without a walk. busy drops in the result cycle, when the
//   next command may already transfer; a full-pool insert never raises busy.
// Reset:
//   Synchronous, active low. The list is empty and every entry is free, with
//   entry i chained to entry i+1; no clearing pass is needed.
`default_nettype none
module sorted_array_linked_list
  import sal_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  start,
  output logic       busy,
  input  wire logic  in_command,
  input  wire key_t  in_key,
  input  wire word_t in_payload,
  output logic       out_strobe,
  output logic [1:0] out_status,
  output pos_t       out_position,
  output word_t      out_found_payload
);

  state_t state_r, state_nxt;
  logic   cmd_r, cmd_nxt;
  key_t   key_r, key_nxt;
  word_t  pay_r, pay_nxt;
  link_t  head_r, head_nxt;
  link_t  free_r, free_nxt;
  link_t  free_link_r, free_link_nxt;
  link_t  cur_r, cur_nxt;
  link_t  prev_r, prev_nxt;
  link_t  steps_r, steps_nxt;

  logic    out_strobe_r, out_strobe_nxt;
  status_t out_status_r, out_status_nxt;
  pos_t    out_position_r, out_position_nxt;
  word_t   out_payload_r, out_payload_nxt;

  store_req_t req;
  store_rsp_t rsp;
  logic       cmp_stop;
  logic       walk_done;
  link_t      next_cur;

  sal_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  // Read data always belongs to cur_r while walking and cur_r is live.
  sal_cmp u_cmp (
    .command    (cmd_r),
    .stored_key (rsp.key),
    .probe_key  (key_r),
    .stop       (cmp_stop)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      head_r       <= NULL_LINK;
      free_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      free_r       <= free_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r          <= cmd_nxt;
    key_r          <= key_nxt;
    pay_r          <= pay_nxt;
    free_link_r    <= free_link_nxt;
    cur_r          <= cur_nxt;
    prev_r         <= prev_nxt;
    steps_r        <= steps_nxt;
    out_status_r   <= out_status_nxt;
    out_position_r <= out_position_nxt;
    out_payload_r  <= out_payload_nxt;
  end

  // Stop on end of list, on the step bound, or on the comparator hit.
  assign walk_done = !is_live(cur_r) || (steps_r == NULL_LINK) || cmp_stop;
  assign next_cur  = link_of(rsp.link);

  always_comb begin
    state_nxt        = state_r;
    cmd_nxt          = cmd_r;
    key_nxt          = key_r;
    pay_nxt          = pay_r;
    head_nxt         = head_r;
    free_nxt         = free_r;
    free_link_nxt    = free_link_r;
    cur_nxt          = cur_r;
    prev_nxt         = prev_r;
    steps_nxt        = steps_r;
    out_strobe_nxt   = 1'b0;
    out_status_nxt   = out_status_r;
    out_position_nxt = out_position_r;
    out_payload_nxt  = out_payload_r;

    req         = '0;
    req.key     = key_r;
    req.payload = pay_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt = in_command;
          key_nxt = in_key;
          pay_nxt = in_payload;
          if (in_command == CMD_SEARCH) begin
            // Start the walk at the head right away.
            cur_nxt     = link_of(head_r);
            steps_nxt   = '0;
            req.rd_en   = 1'b1;
            req.rd_addr = to_idx(head_r);
            state_nxt   = S_WALK;
          end else if (!is_live(free_r)) begin
            out_strobe_nxt   = 1'b1;
            out_status_nxt   = ST_FULL;
            out_position_nxt = '0;
            out_payload_nxt  = '0;
          end else begin
            // Fetch the free slot's link first: it becomes the new free head.
            req.rd_en   = 1'b1;
            req.rd_addr = to_idx(free_r);
            state_nxt   = S_FREE;
          end
        end
      end

      S_FREE: begin
        free_link_nxt = next_cur;
        cur_nxt       = link_of(head_r);
        prev_nxt      = NULL_LINK;
        steps_nxt     = '0;
        req.rd_en     = 1'b1;
        req.rd_addr   = to_idx(head_r);
        state_nxt     = S_WALK;
      end

      S_WALK: begin
        if (walk_done) begin
          if (cmd_r == CMD_SEARCH) begin
            out_strobe_nxt = 1'b1;
            if (is_live(cur_r) && (steps_r != NULL_LINK)) begin
              out_status_nxt   = ST_FOUND;
              out_position_nxt = pos_of(cur_r);
              out_payload_nxt  = rsp.payload;
            end else begin
              out_status_nxt   = ST_NOT_FOUND;
              out_position_nxt = '0;
              out_payload_nxt  = '0;
            end
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_LINK_NEW;
          end
        end else begin
          // Advance one link and read the next entry.
          prev_nxt    = cur_r;
          cur_nxt     = next_cur;
          steps_nxt   = steps_r + LINK_W'(1);
          req.rd_en   = 1'b1;
          req.rd_addr = to_idx(next_cur);
        end
      end

      S_LINK_NEW: begin
        // Fill the new slot and point it at the stopping entry.
        req.kp_we   = 1'b1;
        req.kp_addr = to_idx(free_r);
        req.lk_we   = 1'b1;
        req.lk_addr = to_idx(free_r);
        req.lk_data = cur_r;
        if (!is_live(prev_r)) begin
          head_nxt         = free_r;
          free_nxt         = free_link_r;
          out_strobe_nxt   = 1'b1;
          out_status_nxt   = ST_INSERTED;
          out_position_nxt = pos_of(free_r);
          out_payload_nxt  = '0;
          state_nxt        = S_IDLE;
        end else begin
          state_nxt = S_LINK_PREV;
        end
      end

      S_LINK_PREV: begin
        // Hook the predecessor to the new slot.
        req.lk_we        = 1'b1;
        req.lk_addr      = to_idx(prev_r);
        req.lk_data      = free_r;
        free_nxt         = free_link_r;
        out_strobe_nxt   = 1'b1;
        out_status_nxt   = ST_INSERTED;
        out_position_nxt = pos_of(free_r);
        out_payload_nxt  = '0;
        state_nxt        = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy              = (state_r != S_IDLE);
  assign out_strobe        = out_strobe_r;
  assign out_status        = out_status_r;
  assign out_position      = out_position_r;
  assign out_found_payload = out_payload_r;

endmodule
`default_nettype wire

// ----- rtl/core/sal_store.sv -----
// Entry store: key, payload and link memories with one shared read port.
// Depends on sal_pkg. Links carry per-entry valid bits for their reset chain.
`default_nettype none
module sal_store
  import sal_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire store_req_t req,
  output store_rsp_t      rsp
);

  key_t  key_mem  [ENTRIES];
  word_t pay_mem  [ENTRIES];
  link_t link_mem [ENTRIES];
  logic  valid_r  [ENTRIES];

  key_t  rd_key_r;
  word_t rd_pay_r;
  link_t rd_link_r;

  always_ff @(posedge clk) begin
    if (req.kp_we) begin
      key_mem[req.kp_addr] <= req.key;
      pay_mem[req.kp_addr] <= req.payload;
    end
    if (req.lk_we) begin
      link_mem[req.lk_addr] <= req.lk_data;
    end
  end

  // Unwritten links read as the reset chain: entry i points to i+1.
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_key_r <= key_mem[req.rd_addr];
      rd_pay_r <= pay_mem[req.rd_addr];
      if (valid_r[req.rd_addr]) begin
        rd_link_r <= link_mem[req.rd_addr];
      end else begin
        rd_link_r <= LINK_W'(req.rd_addr) + LINK_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        valid_r[i] <= 1'b0;
      end
    end else if (req.lk_we) begin
      valid_r[req.lk_addr] <= 1'b1;
    end
  end

  assign rsp.key     = rd_key_r;
  assign rsp.payload = rd_pay_r;
  assign rsp.link    = rd_link_r;

endmodule
`default_nettype wire

// ----- rtl/core/sal_cmp.sv -----
// Shared key comparator used at every step of a list walk.
// Depends on sal_pkg. Flags where the walk stops for the current command.
`default_nettype none
module sal_cmp
  import sal_pkg::*;
(
  input  wire logic command,
  input  wire key_t stored_key,
  input  wire key_t probe_key,
  output logic      stop
);

  // Insert stops at the first key not less than the new one; search on equal.
  always_comb begin
    if (command == CMD_SEARCH) begin
      stop = (stored_key == probe_key);
    end else begin
      stop = !(stored_key < probe_key);
    end
  end

endmodule
`default_nettype wire
